// ===== hw/rtl/ucs_pkg.sv =====
// ----------------------------------------------------------------------------
// ucs_pkg: control stage sequencer shared definitions
// Event, result, configuration and sequencer state types, stage and event
// codes, and configuration register indexes.
// ----------------------------------------------------------------------------
package ucs_pkg;

    localparam logic [1:0] FUNC_SETUP   = 2'd0;
    localparam logic [1:0] FUNC_OUT_RX  = 2'd1;
    localparam logic [1:0] FUNC_IN_DONE = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 1'd1;

    localparam logic [6:0]  MPS_MIN        = 7'd8;
    localparam logic [6:0]  MPS_MAX        = 7'd64;
    localparam logic [6:0]  MPS_RESET      = 7'd64;
    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_DATA_IN    = 3'd1,
        ST_LAST_IN    = 3'd2,
        ST_DATA_OUT   = 3'd3,
        ST_LAST_OUT   = 3'd4,
        ST_STATUS_IN  = 3'd5,
        ST_STATUS_OUT = 3'd6
    } stage_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] request_length;
        logic        direction_in;
        logic        handler_ok;
        logic [15:0] reply_length;
        logic        completion_wanted;
        logic [6:0]  packet_bytes;
    } evt_item_t;

    typedef struct packed {
        logic        send_valid;
        logic [6:0]  send_length;
        logic [15:0] buffer_offset;
        logic [6:0]  expected_bytes;
        logic        stall_res;
        logic        nak_on;
        logic        nak_off;
        logic        completion_fired;
        logic [2:0]  stage;
    } res_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          wdata;
    } cfg_item_t;

    typedef struct packed {
        stage_t      stage;
        logic [15:0] saved_length;
        logic [15:0] byte_count;
        logic [15:0] byte_offset;
        logic        completion_pending;
    } seq_state_t;

endpackage

// ===== hw/rtl/ucs_stream_if.sv =====
// ----------------------------------------------------------------------------
// ucs_stream_if: valid/ready channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ucs_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ucs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ucs_cfg_regs: configuration registers
// Holds the clamped endpoint zero packet size and the OUT buffer capacity.
// ----------------------------------------------------------------------------
module ucs_cfg_regs (
    input  logic         clk,
    input  logic         rst_n,
    ucs_stream_if.sink   cfg_ch,
    output logic [6:0]   mps,
    output logic [15:0]  capacity
);

    logic [6:0]  mps_reg;
    logic [6:0]  mps_next;
    logic [15:0] capacity_reg;
    logic [15:0] capacity_next;
    logic [6:0]  wr_mps;
    logic        wr_en;

    assign cfg_ch.ready = 1'b1;
    assign wr_en        = cfg_ch.valid;
    assign wr_mps       = cfg_ch.data.wdata[6:0];

    always_comb
    begin
        mps_next      = mps_reg;
        capacity_next = capacity_reg;
        if (wr_en && cfg_ch.data.index == ucs_pkg::CFG_MAX_PACKET_SIZE)
        begin
            if (wr_mps < ucs_pkg::MPS_MIN)
            begin
                mps_next = ucs_pkg::MPS_MIN;
            end
            else if (wr_mps > ucs_pkg::MPS_MAX)
            begin
                mps_next = ucs_pkg::MPS_MAX;
            end
            else
            begin
                mps_next = wr_mps;
            end
        end
        if (wr_en && cfg_ch.data.index == ucs_pkg::CFG_BUFFER_CAPACITY)
        begin
            capacity_next = cfg_ch.data.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mps_reg      <= ucs_pkg::MPS_RESET;
            capacity_reg <= ucs_pkg::CAPACITY_RESET;
        end
        else
        begin
            mps_reg      <= mps_next;
            capacity_reg <= capacity_next;
        end
    end

    assign mps      = mps_reg;
    assign capacity = capacity_reg;

endmodule

// ===== hw/rtl/ucs_step_logic.sv =====
// ----------------------------------------------------------------------------
// ucs_step_logic: stage transition logic
// Computes the next sequencer state and the result for one event.
// ----------------------------------------------------------------------------
module ucs_step_logic (
    input  ucs_pkg::seq_state_t st,
    input  ucs_pkg::evt_item_t  evt,
    input  logic [6:0]          mps,
    input  logic [15:0]         capacity,
    output ucs_pkg::seq_state_t st_next,
    output ucs_pkg::res_item_t  res
);

    logic [15:0]     mps_w;
    logic [15:0]     setup_count;
    logic [15:0]     chunk_count;
    logic [15:0]     chunk_offset;
    logic            chunk_full;
    logic [6:0]      chunk_len;
    ucs_pkg::stage_t chunk_stage;
    logic [15:0]     chunk_count_next;
    logic [15:0]     chunk_offset_next;
    logic [15:0]     remain;
    logic [6:0]      recv_want;
    logic            recv_match;
    logic [15:0]     remain_after;
    logic [15:0]     recv_count_next;

    assign mps_w       = {9'd0, mps};
    assign setup_count = (evt.reply_length < evt.request_length) ? evt.reply_length
                                                                 : evt.request_length;

    // shared packet split for the IN data stage
    assign chunk_count  = (evt.func == ucs_pkg::FUNC_SETUP) ? setup_count : st.byte_count;
    assign chunk_offset = (evt.func == ucs_pkg::FUNC_SETUP) ? 16'd0 : st.byte_offset;
    assign chunk_full   = mps_w < chunk_count;
    assign chunk_len    = chunk_full ? mps : chunk_count[6:0];
    assign chunk_stage  = chunk_full ? ucs_pkg::ST_DATA_IN : ucs_pkg::ST_LAST_IN;
    assign chunk_count_next  = chunk_full ? chunk_count - mps_w : 16'd0;
    assign chunk_offset_next = chunk_full ? chunk_offset + mps_w : 16'd0;

    // OUT data packet check
    assign remain          = (st.saved_length > st.byte_count) ?
                             st.saved_length - st.byte_count : 16'd0;
    assign recv_want       = (remain < mps_w) ? remain[6:0] : mps;
    assign recv_match      = evt.packet_bytes == recv_want;
    assign remain_after    = remain - {9'd0, recv_want};
    assign recv_count_next = st.byte_count + {9'd0, recv_want};

    always_comb
    begin
        st_next = st;
        res     = '0;
        unique case (evt.func)
            ucs_pkg::FUNC_SETUP:
            begin
                st_next.completion_pending = 1'b0;
                st_next.saved_length       = evt.request_length;
                res.nak_on                 = 1'b1;
                if (evt.request_length == 16'd0 || evt.direction_in)
                begin
                    st_next.completion_pending = evt.completion_wanted;
                    st_next.byte_offset        = 16'd0;
                    st_next.byte_count         = evt.request_length;
                    if (!evt.handler_ok)
                    begin
                        res.stall_res = 1'b1;
                        st_next.stage = ucs_pkg::ST_IDLE;
                    end
                    else if (evt.request_length != 16'd0)
                    begin
                        res.send_valid      = 1'b1;
                        res.send_length     = chunk_len;
                        res.buffer_offset   = chunk_offset;
                        st_next.stage       = chunk_stage;
                        st_next.byte_count  = chunk_count_next;
                        st_next.byte_offset = chunk_offset_next;
                    end
                    else
                    begin
                        res.send_valid     = 1'b1;
                        st_next.byte_count = setup_count;
                        st_next.stage      = ucs_pkg::ST_STATUS_IN;
                    end
                end
                else if (evt.request_length > capacity)
                begin
                    res.stall_res = 1'b1;
                    st_next.stage = ucs_pkg::ST_IDLE;
                end
                else
                begin
                    st_next.byte_offset = 16'd0;
                    st_next.byte_count  = 16'd0;
                    st_next.stage       = (evt.request_length > mps_w) ?
                                          ucs_pkg::ST_DATA_OUT : ucs_pkg::ST_LAST_OUT;
                    res.nak_off         = 1'b1;
                end
            end
            ucs_pkg::FUNC_OUT_RX:
            begin
                unique case (st.stage)
                    ucs_pkg::ST_DATA_OUT,
                    ucs_pkg::ST_LAST_OUT:
                    begin
                        res.buffer_offset  = st.byte_count;
                        res.expected_bytes = recv_want;
                        if (!recv_match)
                        begin
                            res.stall_res = 1'b1;
                            st_next.stage = ucs_pkg::ST_IDLE;
                        end
                        else if (st.stage == ucs_pkg::ST_DATA_OUT)
                        begin
                            st_next.byte_count = recv_count_next;
                            if (remain_after <= mps_w)
                            begin
                                st_next.stage = ucs_pkg::ST_LAST_OUT;
                            end
                        end
                        else
                        begin
                            st_next.byte_count         = recv_count_next;
                            st_next.completion_pending = evt.completion_wanted;
                            if (evt.handler_ok)
                            begin
                                res.send_valid = 1'b1;
                                st_next.stage  = ucs_pkg::ST_STATUS_IN;
                            end
                            else
                            begin
                                res.stall_res = 1'b1;
                                st_next.stage = ucs_pkg::ST_IDLE;
                            end
                        end
                    end
                    ucs_pkg::ST_STATUS_OUT:
                    begin
                        res.completion_fired       = st.completion_pending;
                        st_next.completion_pending = 1'b0;
                        st_next.stage              = ucs_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        res.stall_res = 1'b1;
                        st_next.stage = ucs_pkg::ST_IDLE;
                    end
                endcase
            end
            ucs_pkg::FUNC_IN_DONE:
            begin
                unique case (st.stage)
                    ucs_pkg::ST_DATA_IN:
                    begin
                        res.send_valid      = 1'b1;
                        res.send_length     = chunk_len;
                        res.buffer_offset   = chunk_offset;
                        st_next.stage       = chunk_stage;
                        st_next.byte_count  = chunk_count_next;
                        st_next.byte_offset = chunk_offset_next;
                    end
                    ucs_pkg::ST_LAST_IN:
                    begin
                        res.nak_off   = 1'b1;
                        st_next.stage = ucs_pkg::ST_STATUS_OUT;
                    end
                    ucs_pkg::ST_STATUS_IN:
                    begin
                        res.completion_fired       = st.completion_pending;
                        st_next.completion_pending = 1'b0;
                        st_next.stage              = ucs_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        res.stall_res = 1'b1;
                        st_next.stage = ucs_pkg::ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                st_next = st;
            end
        endcase
        res.stage = st_next.stage;
    end

endmodule

// ===== hw/rtl/usb_control_stage_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// usb_control_stage_sequencer_core: endpoint zero control stage sequencer
// Tracks the stages of a control transfer and reports the endpoint action
// for every event.
// ----------------------------------------------------------------------------
// Usage:
//   evt_ch carries endpoint events (setup, OUT packet received, IN packet
//   done) with the handler's decision flags. Every event yields exactly one
//   result on res_ch: packet send, status packet, NAK set/clear, stall or
//   completion, plus the new stage.
//   cfg_ch writes the packet size (index 0) and the OUT buffer capacity
//   (index 1); it is always ready. Write it only while no event is in flight.
//   The input register loads at the event transfer edge and the result
//   register loads from it once res_ch can take a new result, so the
//   result is registered before it is presented on res_ch.
//   Throughput: one event per cycle barring stalls; the stage logic between
//   the input and result registers is a single pass of compares and 16-bit
//   adds. When res_ch stalls, one event waits in the input register behind
//   the held result and evt_ch ready then follows res_ch ready; nothing is
//   lost. Reset clears the stage to idle, all counters to zero, the packet
//   size to 64 and the capacity to 256.
// ----------------------------------------------------------------------------
module usb_control_stage_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    ucs_stream_if.sink   evt_ch,
    ucs_stream_if.source res_ch,
    ucs_stream_if.sink   cfg_ch
);

    logic                evt_valid_reg;
    logic                evt_valid_next;
    ucs_pkg::evt_item_t  evt_item_reg;
    logic                res_valid_reg;
    logic                res_valid_next;
    ucs_pkg::res_item_t  res_item_reg;
    ucs_pkg::res_item_t  res_item_next;
    ucs_pkg::seq_state_t seq_state_reg;
    ucs_pkg::seq_state_t seq_state_next;
    logic [6:0]          mps;
    logic [15:0]         capacity;
    logic                advance;
    logic                evt_take;

    ucs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_ch   (cfg_ch),
        .mps      (mps),
        .capacity (capacity)
    );

    ucs_step_logic u_step_logic (
        .st       (seq_state_reg),
        .evt      (evt_item_reg),
        .mps      (mps),
        .capacity (capacity),
        .st_next  (seq_state_next),
        .res      (res_item_next)
    );

    assign advance      = evt_valid_reg && (!res_valid_reg || res_ch.ready);
    assign evt_ch.ready = !evt_valid_reg || advance;
    assign evt_take     = evt_ch.valid && evt_ch.ready;

    always_comb
    begin
        evt_valid_next = evt_valid_reg;
        if (evt_take)
        begin
            evt_valid_next = 1'b1;
        end
        else if (advance)
        begin
            evt_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            seq_state_reg <= '{stage: ucs_pkg::ST_IDLE, default: '0};
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                seq_state_reg <= seq_state_next;
            end
        end
    end

    // payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_item_reg <= evt_ch.data;
        end
        if (advance)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_ch.valid = res_valid_reg;
    assign res_ch.data  = res_item_reg;

endmodule

// ===== hw/rtl/ucs_checker.sv =====
// ----------------------------------------------------------------------------
// ucs_checker: port-level checks for the control stage sequencer
// Watches the result channel and flags inconsistent results.
// ----------------------------------------------------------------------------
module ucs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input ucs_pkg::res_item_t res_data
);

    // hold a stalled result until transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.stall_res |-> res_data.stage == ucs_pkg::ST_IDLE
                                            && !res_data.send_valid)
    else $error("stall result does not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.completion_fired |-> res_data.stage == ucs_pkg::ST_IDLE)
    else $error("completion fired outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.send_length <= ucs_pkg::MPS_MAX
                      && (res_data.send_valid || res_data.send_length == 7'd0))
    else $error("bad send length");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.expected_bytes != 7'd0 |-> res_data.send_length == 7'd0
                                                       && !res_data.nak_on
                                                       && !res_data.nak_off)
    else $error("OUT packet result mixed with data send or setup");

endmodule

bind usb_control_stage_sequencer_core ucs_checker u_ucs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .res_data  (res_ch.data)
);
